### hdl/lnh_pkg.sv
// ----------------------------------------------------------------------------
// lnh_pkg
// Shared types, constants and helper functions for the letter n-gram
// histogram core.
// ----------------------------------------------------------------------------
package lnh_pkg;

    // Longest window that the counter store is sized for.
    localparam int MAX_LEN    = 3;
    // Width of one saturating counter.
    localparam int COUNT_BITS = 32;

    localparam int RADIX       = 27;
    localparam int SYM_W       = 5;
    localparam int LEN_W       = $clog2(MAX_LEN + 1);
    localparam int STORE_DEPTH = (MAX_LEN >= 1 ? 27 : 1) * (MAX_LEN >= 2 ? 27 : 1) *
                                 (MAX_LEN >= 3 ? 27 : 1) * (MAX_LEN >= 4 ? 27 : 1);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths of the stream words.
    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int RIDX_W   = 15;
    localparam int OUT_W    = 32;
    localparam int CFG_W    = 2;

    localparam logic [CHAR_W-1:0] CHAR_LC_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_UC_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_SP   = 8'h20;
    localparam logic [SYM_W-1:0]  SPACE_SYM = 5'd26;

    typedef enum logic [ACTION_W-1:0] {
        ACT_START = 2'd0,
        ACT_CHAR  = 2'd1,
        ACT_END   = 2'd2,
        ACT_READ  = 2'd3
    } lnh_action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RD,
        ST_WR,
        ST_RESP
    } lnh_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the accepted item
        logic exec;      // push a symbol or set up a read
        logic clr_wr;    // write one zero of the clearing pass
        logic mem_rd;    // read the counter at the held index
        logic mem_wr;    // write back the incremented counter
        logic load_out;  // move read data into the output register
    } lnh_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_is_read;  // held item is a counter read
        logic push_count;    // the push in progress completes a valid window
        logic clr_last;      // clearing pass is at its last entry
        logic out_full;      // output register holds an untaken word
    } lnh_stat_t;

    // Effective window length: zero counts as one, above MAX_LEN as MAX_LEN.
    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] pl);
        logic [LEN_W-1:0] n;
        if (pl == '0) begin
            n = LEN_W'(1);
        end else if (int'(pl) > MAX_LEN) begin
            n = LEN_W'(MAX_LEN);
        end else begin
            n = LEN_W'(pl);
        end
        return n;
    endfunction

endpackage

### hdl/lnh_ctrl.sv
// ----------------------------------------------------------------------------
// lnh_ctrl
// Sequencer for the histogram core: clearing pass, item intake, counter
// read-modify-write and read responses.
// ----------------------------------------------------------------------------
module lnh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lnh_pkg::lnh_stat_t stat,
    output lnh_pkg::lnh_cmd_t  cmd
);

    lnh_pkg::lnh_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lnh_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // An item may enter once the output register is free or is being emptied.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lnh_pkg::ST_CLEAR: begin
                if (stat.clr_last) begin
                    state_next = lnh_pkg::ST_IDLE;
                end
            end
            lnh_pkg::ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    state_next = lnh_pkg::ST_EXEC;
                end
            end
            lnh_pkg::ST_EXEC: begin
                if (stat.item_is_read || stat.push_count) begin
                    state_next = lnh_pkg::ST_RD;
                end else begin
                    state_next = lnh_pkg::ST_IDLE;
                end
            end
            lnh_pkg::ST_RD: begin
                state_next = stat.item_is_read ? lnh_pkg::ST_RESP : lnh_pkg::ST_WR;
            end
            lnh_pkg::ST_WR:   state_next = lnh_pkg::ST_IDLE;
            lnh_pkg::ST_RESP: state_next = lnh_pkg::ST_IDLE;
            default:          state_next = lnh_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            lnh_pkg::ST_CLEAR: cmd.clr_wr = 1'b1;
            lnh_pkg::ST_IDLE: begin
                s_tready    = !stat.out_full;
                cmd.capture = s_tvalid && !stat.out_full;
            end
            lnh_pkg::ST_EXEC: cmd.exec     = 1'b1;
            lnh_pkg::ST_RD:   cmd.mem_rd   = 1'b1;
            lnh_pkg::ST_WR:   cmd.mem_wr   = 1'b1;
            lnh_pkg::ST_RESP: cmd.load_out = 1'b1;
            default: ;
        endcase
    end

endmodule

### hdl/lnh_datapath.sv
// ----------------------------------------------------------------------------
// lnh_datapath
// Symbol window, counter index arithmetic, counter store and output register.
// ----------------------------------------------------------------------------
module lnh_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [lnh_pkg::CFG_W-1:0]        cfg_data,
    input  logic [lnh_pkg::ACTION_W-1:0]     in_action,
    input  logic [lnh_pkg::CHAR_W-1:0]       in_char,
    input  logic [lnh_pkg::RIDX_W-1:0]       in_ridx,
    input  logic                             out_take,
    output logic                             out_valid,
    output logic [lnh_pkg::OUT_W-1:0]        out_data,
    input  lnh_pkg::lnh_cmd_t                cmd,
    output lnh_pkg::lnh_stat_t               stat
);

    localparam int ML = lnh_pkg::MAX_LEN;
    localparam int AW = lnh_pkg::ADDR_W;
    localparam int LW = lnh_pkg::LEN_W;
    localparam int SW = lnh_pkg::SYM_W;
    localparam int CB = lnh_pkg::COUNT_BITS;

    // Configuration.
    logic [lnh_pkg::CFG_W-1:0] plen_reg;

    // Held item.
    lnh_pkg::lnh_action_t          act_reg;
    logic [lnh_pkg::CHAR_W-1:0]    char_reg;
    logic [lnh_pkg::RIDX_W-1:0]    ridx_reg;

    // Window state.
    logic [SW-1:0] win_reg [ML];
    logic [LW-1:0] fill_reg;
    logic [LW-1:0] bad_reg;

    // Memory access state.
    logic [AW-1:0] idx_reg;
    logic          oor_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [CB-1:0] rd_data_reg;
    logic [CB-1:0] mem [lnh_pkg::STORE_DEPTH];

    logic                  out_valid_reg;
    logic [lnh_pkg::OUT_W-1:0] out_data_reg;

    // Push arithmetic.
    logic [LW-1:0]         n;
    logic [SW-1:0]         base_win [ML];
    logic [SW-1:0]         new_win  [ML];
    logic [LW-1:0]         base_fill, base_bad, fill_new, bad_cnt, bad_after;
    logic [lnh_pkg::CHAR_W-1:0] c_low;
    logic [SW-1:0]         push_sym;
    logic                  push_bad;
    logic                  push_count;
    logic [AW-1:0]         push_idx;
    logic                  ridx_oor;
    logic [CB-1:0]         sat_inc;

    always_comb begin
        n = lnh_pkg::eff_len(plen_reg);

        // A start item clears the window before its space goes in.
        for (int i = 0; i < ML; i++) begin
            base_win[i] = (act_reg == lnh_pkg::ACT_START) ? '0 : win_reg[i];
        end
        base_fill = (act_reg == lnh_pkg::ACT_START) ? '0 : fill_reg;
        base_bad  = (act_reg == lnh_pkg::ACT_START) ? '0 : bad_reg;

        // Fold upper case, then classify the byte.
        c_low = char_reg;
        if (char_reg >= lnh_pkg::CHAR_UC_A && char_reg <= lnh_pkg::CHAR_UC_Z) begin
            c_low = char_reg + (lnh_pkg::CHAR_LC_A - lnh_pkg::CHAR_UC_A);
        end
        push_bad = 1'b0;
        push_sym = lnh_pkg::SPACE_SYM;
        if (act_reg == lnh_pkg::ACT_CHAR) begin
            if (c_low >= lnh_pkg::CHAR_LC_A && c_low <= lnh_pkg::CHAR_LC_Z) begin
                push_sym = SW'(c_low - lnh_pkg::CHAR_LC_A);
            end else if (c_low != lnh_pkg::CHAR_SP) begin
                push_sym = '0;
                push_bad = 1'b1;
            end
        end

        for (int i = 0; i < ML - 1; i++) begin
            new_win[i] = base_win[i + 1];
        end
        new_win[ML-1] = push_sym;

        fill_new   = (int'(base_fill) < ML) ? base_fill + LW'(1) : base_fill;
        bad_cnt    = push_bad ? n : base_bad;
        push_count = (fill_new >= n) && (bad_cnt == '0);
        bad_after  = (bad_cnt != '0) ? bad_cnt - LW'(1) : '0;

        // Base-27 index of the newest n symbols, oldest most significant.
        push_idx = '0;
        for (int i = 0; i < ML; i++) begin
            if (i >= ML - int'(n)) begin
                push_idx = AW'(push_idx * AW'(lnh_pkg::RADIX) + AW'(new_win[i]));
            end
        end

        ridx_oor = 32'(ridx_reg) >= 32'(lnh_pkg::STORE_DEPTH);
        sat_inc  = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + CB'(1);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg      <= lnh_pkg::CFG_W'(3);
            fill_reg      <= '0;
            bad_reg       <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ML; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                plen_reg <= cfg_data;
            end
            if (cmd.clr_wr) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.exec && act_reg != lnh_pkg::ACT_READ) begin
                if (act_reg == lnh_pkg::ACT_END) begin
                    fill_reg <= '0;
                    bad_reg  <= '0;
                    for (int i = 0; i < ML; i++) begin
                        win_reg[i] <= '0;
                    end
                end else begin
                    fill_reg <= fill_new;
                    bad_reg  <= bad_after;
                    win_reg  <= new_win;
                end
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_take) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg  <= lnh_pkg::lnh_action_t'(in_action);
            char_reg <= in_char;
            ridx_reg <= in_ridx;
        end
        if (cmd.exec) begin
            if (act_reg == lnh_pkg::ACT_READ) begin
                idx_reg <= AW'(32'(ridx_reg));
                oor_reg <= ridx_oor;
            end else begin
                idx_reg <= push_idx;
                oor_reg <= 1'b0;
            end
        end
        if (cmd.load_out) begin
            out_data_reg <= oor_reg ? '0 : lnh_pkg::OUT_W'(64'(rd_data_reg));
        end
    end

    // Counter store: one port, written by the clearing pass or the write-back.
    always_ff @(posedge aclk) begin
        if (cmd.clr_wr) begin
            mem[clr_addr_reg] <= '0;
        end else if (cmd.mem_wr) begin
            mem[idx_reg] <= sat_inc;
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign stat.item_is_read = (act_reg == lnh_pkg::ACT_READ);
    assign stat.push_count   = push_count;
    assign stat.clr_last     = (32'(clr_addr_reg) == 32'(lnh_pkg::STORE_DEPTH - 1));
    assign stat.out_full     = out_valid_reg && !out_take;

endmodule

### hdl/letter_ngram_histogram_core.sv
// ----------------------------------------------------------------------------
// letter_ngram_histogram_core
// Counts sliding letter n-grams of a framed text stream and answers reads.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the s_ stream, one per word, with the action in
// s_tuser: start of text, character, end of text or counter read. Start and
// end each add a padding space; characters are folded to lower case. Every
// full window of n symbols (n from the cfg_ length register) made only of
// letters and spaces bumps a saturating 32-bit counter. A read item returns
// one word on m_, zero beyond the store; other items return nothing.
// Sequence. An item passes an accept and a window state, plus a memory read
// and a write-back state if it completes a counted window. A read passes the
// accept, window, read and response states, then its word is valid on m_.
// Reset. After aresetn is released the core clears all 19683 counter entries,
// one entry per cycle, with s_tready low. The length register resets to three;
// the user writes it through cfg_ only while no item is in flight (unchecked).
// Stalls. s_tready is high only while the sequencer is idle, and it stays
// low while a read word waits in the output register for m_tready.
// ----------------------------------------------------------------------------
module letter_ngram_histogram_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: char_code [7:0], read_index [22:8], zero [23].
    input  logic [23:0]                   s_tdata,
    // tuser: action [1:0].
    input  logic [lnh_pkg::ACTION_W-1:0]  s_tuser,
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: count [31:0].
    output logic [lnh_pkg::OUT_W-1:0]     m_tdata,
    // Configuration write channel: window length.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lnh_pkg::CFG_W-1:0]     cfg_data
);

    lnh_pkg::lnh_cmd_t  cmd;
    lnh_pkg::lnh_stat_t stat;

    // The length register accepts a word in every cycle.
    assign cfg_ready = 1'b1;

    lnh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lnh_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .in_action (s_tuser),
        .in_char   (s_tdata[7:0]),
        .in_ridx   (s_tdata[22:8]),
        .out_take  (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
